FILE: rtl/cih_pkg.sv
// Package for the chained integer hash table: sizes, codes and FSM states.
// No dependencies.
package cih_pkg;
    localparam int MaxBuckets = 256;
    localparam int NodeCount  = 256;
    localparam int ValueBits  = 32;
    localparam int BktW  = $clog2(MaxBuckets);
    localparam int NodeW = $clog2(NodeCount);
    localparam int PtrW  = NodeW + 1;
    localparam int CntW  = 9;
    localparam logic [PtrW-1:0] Nil = PtrW'(NodeCount);

    typedef enum logic [2:0] {
        FN_FIND = 3'd0, FN_ENTER = 3'd1, FN_DELETE = 3'd2,
        FN_SCAN_START = 3'd3, FN_SCAN_NEXT = 3'd4, FN_CLEAR = 3'd5,
        FN_RSV6 = 3'd6, FN_RSV7 = 3'd7
    } t_func;

    localparam logic [1:0] ST_OK = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2,
        ST_DONE = 2'd3;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MOD, S_HEAD, S_HEADW, S_NODE, S_NODEW, S_ENT,
        S_DEL, S_SCAN, S_SCANW, S_OUT
    } t_state;
endpackage

FILE: rtl/cih_if.sv
// Valid/ready channel interfaces for the hash table.
// Depends on cih_pkg.
interface cih_req_if import cih_pkg::*; ();
    logic valid, ready;
    logic [2:0] func;
    logic [31:0] key_in, value_in;
    modport source(output valid, func, key_in, value_in, input ready);
    modport sink(input valid, func, key_in, value_in, output ready);
endinterface

interface cih_rsp_if import cih_pkg::*; ();
    logic valid, ready;
    logic [1:0] status_code;
    logic [31:0] key_out, value_out;
    logic [8:0] cell_out;
    modport source(output valid, status_code, key_out, value_out, cell_out, input ready);
    modport sink(input valid, status_code, key_out, value_out, cell_out, output ready);
endinterface

interface cih_cfg_if ();
    logic valid, ready;
    logic [8:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

FILE: rtl/cih_mod.sv
// Bit-serial unsigned remainder of a 32-bit key by the bucket count.
// Depends on cih_pkg.
module cih_mod import cih_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [31:0]     i_key,
    input  logic [CntW-1:0] i_div,
    output logic            o_done,
    output logic [BktW-1:0] o_rem
);
    logic [31:0] r_key;
    logic [CntW:0] r_rem, w_sh;
    logic [5:0] r_cnt;
    logic r_busy;
    assign w_sh = {r_rem[CntW-1:0], r_key[31]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 6'd0;
            r_key <= i_key;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= (w_sh >= {1'b0, i_div}) ? w_sh - {1'b0, i_div} : w_sh;
            r_key <= {r_key[30:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) r_busy <= 1'b0;
        end
    end
    assign o_done = r_busy && r_cnt == 6'd32 ? 1'b0 : (!r_busy && r_cnt == 6'd32);
    assign o_rem = r_rem[BktW-1:0];
endmodule

FILE: rtl/chained_int_hash_table_top.sv
// Top level of the chained integer hash table: sequencer and node/bucket memories.
// Depends on cih_pkg, cih_if and cih_mod.
// Sequence: find/enter/delete take the key's remainder by the bucket count, then read
// the bucket head; enter links a free node in at the head, find/delete walk the chain
// comparing keys; scan skips empty buckets; clear resets all; codes 6/7 reply directly.
// Throughput: one transaction at a time; ready again the cycle after the result is taken.
// Reset: synchronous active-low; bucket count 251, then a pass clearing all buckets.
module chained_int_hash_table_top import cih_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    cih_req_if.sink   i_req,
    cih_rsp_if.source o_rsp,
    cih_cfg_if.sink   i_cfg
);
    logic [PtrW-1:0] m_head [MaxBuckets];
    logic [PtrW-1:0] m_link [NodeCount];
    logic [31:0]     m_key  [NodeCount];
    logic [ValueBits-1:0] m_val [NodeCount];

    t_state r_state, n_state;
    logic [CntW-1:0] r_bc;
    logic [2:0] r_func;
    logic [31:0] r_key, r_vin;
    logic [BktW:0] r_clr;
    logic [PtrW-1:0] r_free, r_n, r_prev, r_sn;
    logic [CntW-1:0] r_sb;
    logic [BktW-1:0] r_b;
    logic [PtrW-1:0] r_hd, r_lk;
    logic [31:0] r_nk;
    logic [ValueBits-1:0] r_nv;
    logic [1:0] r_st;
    logic [31:0] r_ko, r_vo;
    logic [8:0] r_co;
    logic [CntW-1:0] w_cnt;
    logic w_mdone, w_mstart;
    logic [BktW-1:0] w_rem;

    assign w_cnt = (r_bc == '0) ? CntW'(1) :
                   (r_bc > CntW'(MaxBuckets)) ? CntW'(MaxBuckets) : r_bc;
    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign w_mstart = i_req.valid && i_req.ready &&
        (i_req.func == FN_FIND || i_req.func == FN_ENTER || i_req.func == FN_DELETE);

    cih_mod u_mod (.i_clk, .i_rst_n, .i_start(w_mstart), .i_key(i_req.key_in),
        .i_div(w_cnt), .o_done(w_mdone), .o_rem(w_rem));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_clr == (BktW+1)'(MaxBuckets-1)) begin
                n_state = (r_func == FN_CLEAR) ? S_OUT : S_IDLE;
            end
            S_IDLE:  begin
                if (i_cfg.valid) n_state = S_CLR;
                else if (i_req.valid) begin
                    priority case (t_func'(i_req.func))
                        FN_FIND, FN_ENTER, FN_DELETE: n_state = S_MOD;
                        FN_SCAN_START, FN_SCAN_NEXT:  n_state = S_SCAN;
                        FN_CLEAR: n_state = S_CLR;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_MOD:   if (w_mdone) n_state = S_HEAD;
            S_HEAD:  n_state = S_HEADW;
            S_HEADW: n_state = (r_func == FN_ENTER) ? S_ENT : S_NODE;
            S_NODE:  n_state = (r_n == Nil) ? S_OUT : S_NODEW;
            S_NODEW: n_state = (r_nk == r_key) ? ((r_func == FN_DELETE) ? S_DEL : S_OUT)
                               : S_NODE;
            S_ENT:   n_state = S_OUT;
            S_DEL:   n_state = S_OUT;
            S_SCAN:  n_state = (r_sb >= w_cnt) ? S_OUT : S_SCANW;
            S_SCANW: n_state = (r_sn != Nil) ? S_OUT : S_SCAN;
            S_OUT:   if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.status_code = r_st;
    assign o_rsp.key_out = r_ko;
    assign o_rsp.value_out = r_vo;
    assign o_rsp.cell_out = r_co;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_bc <= CntW'(251);
            r_free <= '0;
            r_sb <= CntW'(251);
            r_sn <= Nil;
            r_func <= FN_FIND;
        end else begin
            r_state <= n_state;
            r_hd <= m_head[r_b];
            if (r_n != Nil) begin
                r_lk <= m_link[r_n[NodeW-1:0]];
                r_nk <= m_key[r_n[NodeW-1:0]];
                r_nv <= m_val[r_n[NodeW-1:0]];
            end
            unique case (r_state)
                S_CLR: begin
                    m_head[r_clr[BktW-1:0]] <= Nil;
                    m_link[r_clr[NodeW-1:0]] <= PtrW'(r_clr) + PtrW'(1);
                    r_clr <= (r_clr == (BktW+1)'(MaxBuckets-1)) ? '0 : r_clr + 1'b1;
                    r_free <= '0;
                    r_sb <= w_cnt;
                    r_sn <= Nil;
                end
                S_IDLE: begin
                    r_st <= ST_OK; r_ko <= '0; r_vo <= '0; r_co <= '0;
                    r_func <= i_cfg.valid ? FN_FIND : i_req.func;
                    r_key <= i_req.key_in; r_vin <= i_req.value_in;
                    if (i_cfg.valid) r_bc <= i_cfg.data;
                    else if (i_req.valid && i_req.func == FN_SCAN_START) begin
                        r_sb <= '0; r_b <= '0;
                        r_sn <= m_head[0];
                    end else if (i_req.valid && i_req.func == FN_SCAN_NEXT) begin
                        r_b <= r_sb[BktW-1:0];
                    end
                end
                S_MOD:  r_b <= w_rem;
                S_HEAD: r_prev <= Nil;
                S_HEADW: begin
                    r_n <= (r_func == FN_ENTER && r_free != Nil) ? r_free : r_hd;
                    if (r_func != FN_ENTER) r_st <= ST_MISS;
                    else if (r_free == Nil) r_st <= ST_FULL;
                end
                S_NODEW: begin
                    if (r_nk == r_key) begin
                        if (r_func == FN_FIND) begin
                            r_st <= ST_OK;
                            r_vo <= 32'(r_nv);
                        end
                    end else begin
                        r_prev <= r_n;
                        r_n <= r_lk;
                    end
                end
                S_ENT: if (r_st == ST_OK) begin
                    r_free <= m_link[r_n[NodeW-1:0]];
                    m_link[r_n[NodeW-1:0]] <= r_hd;
                    m_head[r_b] <= r_n;
                    m_key[r_n[NodeW-1:0]] <= r_key;
                    m_val[r_n[NodeW-1:0]] <= r_vin[ValueBits-1:0];
                end
                S_DEL: begin
                    r_st <= ST_OK;
                    if (r_prev != Nil) m_link[r_prev[NodeW-1:0]] <= r_lk;
                    else m_head[r_b] <= r_lk;
                    if (r_sn == r_n) r_sn <= r_lk;
                    m_link[r_n[NodeW-1:0]] <= r_free;
                    r_free <= r_n;
                end
                S_SCAN: begin
                    r_st <= ST_DONE;
                    r_n <= r_sn;
                end
                S_SCANW: begin
                    if (r_sn != Nil) begin
                        r_st <= ST_OK;
                        r_ko <= m_key[r_n[NodeW-1:0]];
                        r_vo <= 32'(m_val[r_n[NodeW-1:0]]);
                        r_co <= 9'(r_sb) + 9'd1;
                        r_sn <= m_link[r_n[NodeW-1:0]];
                    end else begin
                        r_sb <= r_sb + 1'b1;
                        r_b <= r_b + 1'b1;
                        r_sn <= ((r_sb + 1'b1) < w_cnt) ?
                            m_head[BktW'(r_sb + 1'b1)] : Nil;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/cih_checker.sv
// Port-level assertions for the hash table top, attached by bind.
// Depends on chained_int_hash_table_top and its cih_if ports.
module cih_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic rq_v, rq_r, rs_v, rs_r, cf_r,
    input logic [1:0] st
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rs_v && !rs_r |=> rs_v && $stable(st)) else $error("response dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_v && rq_r |=> !rq_r) else $error("ready after accept");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rs_v |-> !rq_r && !cf_r) else $error("ready while result pending");
endmodule

bind chained_int_hash_table_top cih_checker u_chk (.i_clk, .i_rst_n,
    .rq_v(i_req.valid), .rq_r(i_req.ready), .rs_v(o_rsp.valid), .rs_r(o_rsp.ready),
    .cf_r(i_cfg.ready), .st(o_rsp.status_code));

FILE: tb/tb_chained_int_hash_table_top.sv
// Testbench for the chained integer hash table top level: directed and random
// find/enter/delete/scan/clear traffic checked against a behavioural table model.
// Depends on cih_pkg, cih_if and chained_int_hash_table_top.
`timescale 1ns / 1ps

module tb_chained_int_hash_table_top;
    import cih_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] key;
        logic [31:0] value;
        logic [8:0]  bkt;
    } t_rsp;

    localparam int WatchLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cih_req_if req_if ();
    cih_rsp_if rsp_if ();
    cih_cfg_if cfg_if ();

    chained_int_hash_table_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table model
    int unsigned mdl_count;
    int unsigned mdl_heads [MaxBuckets];
    logic [31:0] mdl_keys [NodeCount];
    logic [31:0] mdl_vals [NodeCount];
    int unsigned mdl_links [NodeCount];
    int unsigned mdl_free;
    int unsigned mdl_scan_bkt;
    int unsigned mdl_scan_node;

    t_rsp expected_rsps [$];
    int   mismatches = 0;
    int   watch = 0;
    int   rsp_wait = 0;
    logic hold_off = 1'b0;
    logic timed_out = 1'b0;

    function automatic int unsigned eff_count();
        if (mdl_count == 0) return 1;
        if (mdl_count > MaxBuckets) return MaxBuckets;
        return mdl_count;
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < MaxBuckets; i++) mdl_heads[i] = NodeCount;
        for (int i = 0; i < NodeCount; i++) mdl_links[i] = i + 1;
        mdl_free = 0;
        mdl_scan_bkt = eff_count();
        mdl_scan_node = NodeCount;
    endfunction

    function automatic t_rsp table_step(t_func fn, logic [31:0] key, logic [31:0] val);
        t_rsp r;
        int unsigned cnt, b, n, prev;
        r = '0;
        cnt = eff_count();
        b = key % cnt;
        case (fn)
            FN_FIND: begin
                r.status = ST_MISS;
                n = mdl_heads[b];
                while (n < NodeCount) begin
                    if (mdl_keys[n] == key) begin
                        r.status = ST_OK;
                        r.value = mdl_vals[n];
                        break;
                    end
                    n = mdl_links[n];
                end
            end
            FN_ENTER: begin
                if (mdl_free >= NodeCount) begin
                    r.status = ST_FULL;
                end else begin
                    n = mdl_free;
                    mdl_free = mdl_links[n];
                    mdl_links[n] = mdl_heads[b];
                    mdl_heads[b] = n;
                    mdl_keys[n] = key;
                    mdl_vals[n] = val;
                end
            end
            FN_DELETE: begin
                r.status = ST_MISS;
                prev = NodeCount;
                n = mdl_heads[b];
                while (n < NodeCount) begin
                    if (mdl_keys[n] == key) begin
                        if (prev < NodeCount) mdl_links[prev] = mdl_links[n];
                        else mdl_heads[b] = mdl_links[n];
                        if (mdl_scan_node == n) mdl_scan_node = mdl_links[n];
                        mdl_links[n] = mdl_free;
                        mdl_free = n;
                        r.status = ST_OK;
                        break;
                    end
                    prev = n;
                    n = mdl_links[n];
                end
            end
            FN_SCAN_START, FN_SCAN_NEXT: begin
                if (fn == FN_SCAN_START) begin
                    mdl_scan_bkt = 0;
                    mdl_scan_node = mdl_heads[0];
                end
                r.status = ST_DONE;
                while (mdl_scan_bkt < cnt) begin
                    if (mdl_scan_node < NodeCount) begin
                        r.status = ST_OK;
                        r.key = mdl_keys[mdl_scan_node];
                        r.value = mdl_vals[mdl_scan_node];
                        r.bkt = 9'(mdl_scan_bkt + 1);
                        mdl_scan_node = mdl_links[mdl_scan_node];
                        break;
                    end
                    mdl_scan_bkt++;
                    mdl_scan_node = (mdl_scan_bkt < cnt) ? mdl_heads[mdl_scan_bkt] : NodeCount;
                end
            end
            FN_CLEAR: table_clear();
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_op(t_func fn, logic [31:0] key, logic [31:0] val);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func <= fn;
        req_if.key_in <= key;
        req_if.value_in <= val;
        do @(posedge i_clk); while (!req_if.ready);
        expected_rsps.push_back(table_step(fn, key, val));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [8:0] cnt);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data <= cnt;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        mdl_count = cnt;
        table_clear();
    endtask

    function automatic logic [31:0] pick_key(int unsigned span);
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $urandom_range(0, span);
    endfunction

    task automatic test_directed();
        send_op(FN_SCAN_NEXT, 0, 0);
        send_op(FN_FIND, 32'hFFFF_FFFF, 0);
        send_op(FN_ENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FN_ENTER, 32'h0, 32'h0);
        send_op(FN_ENTER, 32'd251, 32'h1234_5678);
        send_op(FN_ENTER, 32'd251, 32'hA5A5_5A5A);
        send_op(FN_FIND, 32'd251, 0);
        send_op(FN_FIND, 32'hFFFF_FFFF, 0);
        send_op(FN_SCAN_START, 0, 0);
        send_op(FN_DELETE, 32'd251, 0);
        send_op(FN_SCAN_NEXT, 0, 0);
        send_op(FN_SCAN_NEXT, 0, 0);
        send_op(FN_SCAN_NEXT, 0, 0);
        send_op(FN_SCAN_NEXT, 0, 0);
        send_op(FN_FIND, 32'd251, 0);
        send_op(FN_DELETE, 32'd7, 0);
        send_op(FN_RSV6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FN_RSV7, 0, 0);
        send_op(FN_CLEAR, 0, 0);
        send_op(FN_FIND, 32'h0, 0);
        send_op(FN_SCAN_START, 0, 0);
    endtask

    task automatic test_pool_full();
        for (int i = 0; i < NodeCount + 3; i++) send_op(FN_ENTER, $urandom(), $urandom());
        send_op(FN_DELETE, 32'h5, 0);
        send_op(FN_SCAN_START, 0, 0);
        repeat (5) send_op(FN_SCAN_NEXT, 0, 0);
        send_op(FN_CLEAR, 0, 0);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (6) send_op(FN_ENTER, $urandom_range(0, 40), $urandom());
        join
    endtask

    task automatic test_random(int n, int unsigned span);
        int unsigned sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) send_op(FN_ENTER, pick_key(span), $urandom());
            else if (sel < 50) send_op(FN_FIND, pick_key(span), 0);
            else if (sel < 65) send_op(FN_DELETE, pick_key(span), 0);
            else if (sel < 70) send_op(FN_SCAN_START, 0, 0);
            else if (sel < 96) send_op(FN_SCAN_NEXT, 0, 0);
            else if (sel < 98) send_op(FN_CLEAR, 0, 0);
            else send_op(t_func'($urandom_range(6, 7)), $urandom(), $urandom());
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_wait <= $urandom_range(0, 18);
        end else if (rsp_if.valid && rsp_if.ready) begin
            rsp_if.ready <= 1'b0;
            rsp_wait <= $urandom_range(0, 18);
        end else if (hold_off) begin
            rsp_if.ready <= 1'b0;
        end else if (!rsp_if.ready) begin
            if (rsp_wait == 0) rsp_if.ready <= 1'b1;
            else rsp_wait <= rsp_wait - 1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp got, want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.status_code, rsp_if.key_out, rsp_if.value_out, rsp_if.cell_out};
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %h", got);
            end else begin
                want = expected_rsps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: st %0d/%0d key %h/%h val %h/%h cell %0d/%0d",
                            want.status, got.status, want.key, got.key,
                            want.value, got.value, want.bkt, got.bkt);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready) || hold_off) begin
            watch <= 0;
        end else begin
            watch <= watch + 1;
        end
        if (watch >= WatchLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("[chained_int_hash_table_top] ERROR");
            $finish;
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.func = FN_FIND;
        req_if.key_in = '0;
        req_if.value_in = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        mdl_count = 251;
        table_clear();
        for (int i = 0; i < NodeCount; i++) begin
            mdl_keys[i] = '0;
            mdl_vals[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(300, 600);
        write_buckets(9'd1);
        test_random(150, 50);
        write_buckets(9'd256);
        test_pool_full();
        test_random(200, 2000);
        write_buckets(9'd0);
        test_random(80, 30);
        write_buckets(9'd511);
        test_random(200, 1000);
        write_buckets(9'd7);
        test_random(300, 60);
        write_buckets(9'd251);
        test_random(180, 500);
        wait_drained();
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("[chained_int_hash_table_top] OK");
        end else begin
            $display("[chained_int_hash_table_top] ERROR");
        end
        $finish;
    end
endmodule
